// ===== design/ssa_pkg.sv =====
// Shared constants for the separation steering accumulator.
// Widths of the serial arithmetic units and the configuration register indexes.
// No dependencies.
package ssa_pkg;

  // Serial multiplier operand width and its product width.
  localparam int MUL_W = 24;
  localparam int PROD_W = 2 * MUL_W;

  // Divider dividend and divisor widths.
  localparam int DVD_W = 54;
  localparam int DVS_W = 32;

  // Square root radicand and root widths.
  localparam int RAD_W = 64;
  localparam int ROOT_W = RAD_W / 2;

  // Push accumulator and configuration register widths.
  localparam int ACC_W = 24;
  localparam int CFG_W = 23;
  localparam int CFG_AW = 2;

  localparam logic [CFG_AW-1:0] REG_SEP_RADIUS = 2'd0;
  localparam logic [CFG_AW-1:0] REG_MAX_PUSH = 2'd1;
  localparam logic [CFG_AW-1:0] REG_MIN_DISTANCE = 2'd2;
  localparam logic [CFG_AW-1:0] REG_MIN_PUSH = 2'd3;

endpackage

// ===== design/ssa_mul.sv =====
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
// Depends on ssa_pkg for the operand width.
module ssa_mul import ssa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  localparam int CNT_W = $clog2(MUL_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [MUL_W-1:0]  a_r;
  logic [PROD_W-1:0] p_r;
  logic [MUL_W:0]    hi_sum;
  logic [PROD_W-1:0] p_nxt;

  assign hi_sum = {1'b0, p_r[PROD_W-1:MUL_W]} + (p_r[0] ? {1'b0, a_r} : '0);
  assign p_nxt = {hi_sum, p_r[MUL_W-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          busy_r <= 1'b1;
          cnt_r <= '0;
        end
      end else begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      a_r <= a;
      p_r <= {{MUL_W{1'b0}}, b};
    end else if (busy_r) begin
      p_r <= p_nxt;
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

// ===== design/ssa_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ssa_pkg for the dividend and divisor widths.
module ssa_div import ssa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // The dividend shifts out at the top while quotient bits shift in below.
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign ge = trial >= {1'b0, dvs_r};
  assign diff = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          busy_r <= 1'b1;
          cnt_r <= '0;
        end
      end else begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign done = done_r;
  assign quotient = dvd_r;

endmodule

// ===== design/ssa_sqrt.sv =====
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on ssa_pkg for the radicand and root widths.
module ssa_sqrt import ssa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 2;

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [REM_W+1:0]  rem_t;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              ge;

  assign rem_t = {rem_r, rad_r[RAD_W-1:RAD_W-2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign ge = rem_t >= trial;
  assign diff = rem_t - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          busy_r <= 1'b1;
          cnt_r <= '0;
        end
      end else begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      rad_r <= radicand;
      rem_r <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r <= ge ? diff[REM_W-1:0] : rem_t[REM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== design/separation_steering_accumulator.sv =====
// Separation steering accumulator: sums falloff-weighted away vectors of neighbors
// and emits the clamped push. Depends on ssa_pkg, ssa_mul, ssa_div and ssa_sqrt.
//
// One neighbor takes two squarings, a square root, three divisions and two
// products, all run one after the other on a single shared bit-serial multiplier,
// divider and two-bit-per-cycle square root unit. An item without a neighbor, or
// one out of range, skips the arithmetic; one within the minimum distance or
// outside the radius stops after the squarings or the square root. A last item
// adds the length test and the scaling of an over-long push. The result sits in an
// output register, so the next transaction is taken while it waits to be read.
module separation_steering_accumulator import ssa_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // agent_x, agent_z, neighbor_x, neighbor_z from the lowest bit up
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]     in_tdata,
  // neighbor_present
  input  logic                                   in_tuser,
  // last_neighbor
  input  logic                                   in_tlast,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // push_x, push_z from the lowest bit up
  output logic [2*ACC_W-1:0]                     out_tdata,
  input  logic                                   cfg_we,
  input  logic [CFG_AW-1:0]                      cfg_addr,
  input  logic [CFG_W-1:0]                       cfg_wdata
);

  localparam int CW = COORD_WIDTH;
  localparam int DXW = CW + 1;
  localparam int MAG_W = 23;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_PREP = 5'd1;
  localparam logic [4:0] S_SQX = 5'd2;
  localparam logic [4:0] S_SQZ = 5'd3;
  localparam logic [4:0] S_TEST = 5'd4;
  localparam logic [4:0] S_SQRT = 5'd5;
  localparam logic [4:0] S_WDIV = 5'd6;
  localparam logic [4:0] S_UXDIV = 5'd7;
  localparam logic [4:0] S_UXMUL = 5'd8;
  localparam logic [4:0] S_UZDIV = 5'd9;
  localparam logic [4:0] S_UZMUL = 5'd10;
  localparam logic [4:0] S_FIN = 5'd11;
  localparam logic [4:0] S_LX = 5'd12;
  localparam logic [4:0] S_LZ = 5'd13;
  localparam logic [4:0] S_LMIN = 5'd14;
  localparam logic [4:0] S_LMAX = 5'd15;
  localparam logic [4:0] S_LSQRT = 5'd16;
  localparam logic [4:0] S_NXMUL = 5'd17;
  localparam logic [4:0] S_NXDIV = 5'd18;
  localparam logic [4:0] S_NZMUL = 5'd19;
  localparam logic [4:0] S_NZDIV = 5'd20;
  localparam logic [4:0] S_EMIT = 5'd21;

  logic [4:0] state_r, state_nxt;

  // Configuration registers.
  logic [CFG_W-1:0] sep_radius_r;
  logic [CFG_W-1:0] max_push_r;
  logic [7:0]       min_distance_r;
  logic [15:0]      min_push_r;

  // Item and working registers.
  logic signed [DXW-1:0] dx_r, dz_r;
  logic                  present_r, last_r;
  logic [MAG_W-1:0]      adx_r, adz_r;
  logic [PROD_W-1:0]     d2_r;
  logic [ROOT_W-1:0]     dq_r;
  logic [16:0]           w_r;
  logic [ACC_W-1:0]      acc_x_r, acc_z_r;
  logic [ACC_W-1:0]      res_x_r, res_z_r;
  logic                  out_valid_r;
  logic [ACC_W-1:0]      out_x_r, out_z_r;

  // Arithmetic unit hookup.
  logic              mul_go, mul_done;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_prod;
  logic              div_go, div_done;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic [DVD_W-1:0]  div_quo;
  logic              sq_go, sq_done;
  logic [RAD_W-1:0]  sq_rad;
  logic [ROOT_W-1:0] sq_root;

  ssa_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_go), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  ssa_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go), .dividend(div_dvd), .divisor(div_dvs),
    .done(div_done), .quotient(div_quo)
  );

  ssa_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_go), .radicand(sq_rad),
    .done(sq_done), .root(sq_root)
  );

  // Input unpacking and the position differences.
  logic signed [CW-1:0]  ax, az, nx, nz;
  logic signed [DXW-1:0] dx_in, dz_in;

  assign ax = in_tdata[CW-1:0];
  assign az = in_tdata[2*CW-1:CW];
  assign nx = in_tdata[3*CW-1:2*CW];
  assign nz = in_tdata[4*CW-1:3*CW];
  assign dx_in = DXW'(ax) - DXW'(nx);
  assign dz_in = DXW'(az) - DXW'(nz);

  // Magnitudes of the differences; anything at or above 2^23 is out of range.
  logic [DXW-1:0]       dx_mag, dz_mag;
  logic [DXW+MAG_W-1:0] dx_ext, dz_ext;
  logic                 far;

  assign dx_mag = dx_r[DXW-1] ? DXW'(-dx_r) : DXW'(dx_r);
  assign dz_mag = dz_r[DXW-1] ? DXW'(-dz_r) : DXW'(dz_r);
  assign dx_ext = {{MAG_W{1'b0}}, dx_mag};
  assign dz_ext = {{MAG_W{1'b0}}, dz_mag};
  assign far = (|dx_ext[DXW+MAG_W-1:MAG_W]) || (|dz_ext[DXW+MAG_W-1:MAG_W]);

  // Radius in 1/256 units and the falloff numerator.
  logic [30:0] r_big;
  logic [30:0] r_minus_dq;
  logic        radius_hit;
  logic [15:0] md_sq;

  assign r_big = {sep_radius_r, 8'b0};
  assign radius_hit = {1'b0, r_big} > sq_root;
  assign r_minus_dq = r_big - sq_root[30:0];
  assign md_sq = {8'b0, min_distance_r} * {8'b0, min_distance_r};

  // Push magnitudes.
  logic [ACC_W-1:0] px_mag, pz_mag;

  assign px_mag = acc_x_r[ACC_W-1] ? ACC_W'(-acc_x_r) : acc_x_r;
  assign pz_mag = acc_z_r[ACC_W-1] ? ACC_W'(-acc_z_r) : acc_z_r;

  // Term of one component and its saturating add.
  logic [16:0]      term;
  logic [ACC_W:0]   term_ext;
  logic [ACC_W:0]   sum_x, sum_z;
  logic [ACC_W-1:0] sat_x, sat_z;

  assign term = mul_prod[32:16];
  assign term_ext = {{(ACC_W-16){1'b0}}, term};
  assign sum_x = dx_r[DXW-1] ? {acc_x_r[ACC_W-1], acc_x_r} - term_ext
                             : {acc_x_r[ACC_W-1], acc_x_r} + term_ext;
  assign sum_z = dz_r[DXW-1] ? {acc_z_r[ACC_W-1], acc_z_r} - term_ext
                             : {acc_z_r[ACC_W-1], acc_z_r} + term_ext;
  assign sat_x = (sum_x[ACC_W] != sum_x[ACC_W-1]) ?
                 (sum_x[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}})
                 : sum_x[ACC_W-1:0];
  assign sat_z = (sum_z[ACC_W] != sum_z[ACC_W-1]) ?
                 (sum_z[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}})
                 : sum_z[ACC_W-1:0];

  // Scaled component, limited to max_push, with the sign put back.
  logic [CFG_W-1:0] scaled;
  logic             scale_neg;
  logic [ACC_W-1:0] scaled_out;

  assign scaled = (div_quo > {{(DVD_W-CFG_W){1'b0}}, max_push_r}) ? max_push_r
                                                                   : div_quo[CFG_W-1:0];
  assign scale_neg = (state_r == S_NXDIV) ? acc_x_r[ACC_W-1] : acc_z_r[ACC_W-1];
  assign scaled_out = scale_neg ? ACC_W'(-{1'b0, scaled}) : {1'b0, scaled};

  logic emit_fire;
  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  // Sequencer: next state and the operands of the shared units.
  always_comb begin
    state_nxt = state_r;
    mul_go = 1'b0;
    mul_a = '0;
    mul_b = '0;
    div_go = 1'b0;
    div_dvd = '0;
    div_dvs = '0;
    sq_go = 1'b0;
    sq_rad = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_PREP;
      end
      S_PREP: begin
        if (!present_r || far) begin
          state_nxt = S_FIN;
        end else begin
          mul_go = 1'b1;
          mul_a = {1'b0, dx_ext[MAG_W-1:0]};
          mul_b = {1'b0, dx_ext[MAG_W-1:0]};
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        if (mul_done) begin
          mul_go = 1'b1;
          mul_a = {1'b0, adz_r};
          mul_b = {1'b0, adz_r};
          state_nxt = S_SQZ;
        end
      end
      S_SQZ: begin
        if (mul_done) state_nxt = S_TEST;
      end
      S_TEST: begin
        if (d2_r > {{(PROD_W-16){1'b0}}, md_sq}) begin
          sq_go = 1'b1;
          sq_rad = {d2_r, 16'b0};
          state_nxt = S_SQRT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          if (radius_hit) begin
            div_go = 1'b1;
            div_dvd = {7'b0, r_minus_dq, 16'b0};
            div_dvs = {1'b0, r_big};
            state_nxt = S_WDIV;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_WDIV: begin
        if (div_done) begin
          div_go = 1'b1;
          div_dvd = {7'b0, adx_r, 24'b0};
          div_dvs = dq_r;
          state_nxt = S_UXDIV;
        end
      end
      S_UXDIV: begin
        if (div_done) begin
          mul_go = 1'b1;
          mul_a = div_quo[MUL_W-1:0];
          mul_b = {7'b0, w_r};
          state_nxt = S_UXMUL;
        end
      end
      S_UXMUL: begin
        if (mul_done) begin
          div_go = 1'b1;
          div_dvd = {7'b0, adz_r, 24'b0};
          div_dvs = dq_r;
          state_nxt = S_UZDIV;
        end
      end
      S_UZDIV: begin
        if (div_done) begin
          mul_go = 1'b1;
          mul_a = div_quo[MUL_W-1:0];
          mul_b = {7'b0, w_r};
          state_nxt = S_UZMUL;
        end
      end
      S_UZMUL: begin
        if (mul_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (sep_radius_r == '0) begin
          state_nxt = S_EMIT;
        end else begin
          mul_go = 1'b1;
          mul_a = px_mag;
          mul_b = px_mag;
          state_nxt = S_LX;
        end
      end
      S_LX: begin
        if (mul_done) begin
          mul_go = 1'b1;
          mul_a = pz_mag;
          mul_b = pz_mag;
          state_nxt = S_LZ;
        end
      end
      S_LZ: begin
        if (mul_done) begin
          mul_go = 1'b1;
          mul_a = {8'b0, min_push_r};
          mul_b = {8'b0, min_push_r};
          state_nxt = S_LMIN;
        end
      end
      S_LMIN: begin
        if (mul_done) begin
          if (d2_r < mul_prod) begin
            state_nxt = S_EMIT;
          end else begin
            mul_go = 1'b1;
            mul_a = {1'b0, max_push_r};
            mul_b = {1'b0, max_push_r};
            state_nxt = S_LMAX;
          end
        end
      end
      S_LMAX: begin
        if (mul_done) begin
          if (d2_r > mul_prod) begin
            sq_go = 1'b1;
            sq_rad = {d2_r, 16'b0};
            state_nxt = S_LSQRT;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_LSQRT: begin
        if (sq_done) begin
          mul_go = 1'b1;
          mul_a = px_mag;
          mul_b = {1'b0, max_push_r};
          state_nxt = S_NXMUL;
        end
      end
      S_NXMUL: begin
        if (mul_done) begin
          div_go = 1'b1;
          div_dvd = {mul_prod[DVD_W-9:0], 8'b0};
          div_dvs = dq_r;
          state_nxt = S_NXDIV;
        end
      end
      S_NXDIV: begin
        if (div_done) begin
          mul_go = 1'b1;
          mul_a = pz_mag;
          mul_b = {1'b0, max_push_r};
          state_nxt = S_NZMUL;
        end
      end
      S_NZMUL: begin
        if (mul_done) begin
          div_go = 1'b1;
          div_dvd = {mul_prod[DVD_W-9:0], 8'b0};
          div_dvs = dq_r;
          state_nxt = S_NZDIV;
        end
      end
      S_NZDIV: begin
        if (div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_fire) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state, configuration and the push accumulator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      sep_radius_r <= CFG_W'(512);
      max_push_r <= CFG_W'(65536);
      min_distance_r <= 8'd1;
      min_push_r <= 16'd1;
      acc_x_r <= '0;
      acc_z_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_SEP_RADIUS:   sep_radius_r <= cfg_wdata;
          REG_MAX_PUSH:     max_push_r <= cfg_wdata;
          REG_MIN_DISTANCE: min_distance_r <= cfg_wdata[7:0];
          REG_MIN_PUSH:     min_push_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (state_r == S_UXMUL && mul_done) acc_x_r <= sat_x;
      if (state_r == S_UZMUL && mul_done) acc_z_r <= sat_z;
      if (emit_fire) begin
        acc_x_r <= '0;
        acc_z_r <= '0;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      dx_r <= dx_in;
      dz_r <= dz_in;
      present_r <= in_tuser;
      last_r <= in_tlast;
    end
    if (state_r == S_PREP) begin
      adx_r <= dx_ext[MAG_W-1:0];
      adz_r <= dz_ext[MAG_W-1:0];
    end
    if ((state_r == S_SQX || state_r == S_LX) && mul_done) d2_r <= mul_prod;
    if ((state_r == S_SQZ || state_r == S_LZ) && mul_done) d2_r <= d2_r + mul_prod;
    if ((state_r == S_SQRT || state_r == S_LSQRT) && sq_done) dq_r <= sq_root;
    if (state_r == S_WDIV && div_done) w_r <= div_quo[16:0];
    if (state_r == S_FIN) begin
      res_x_r <= '0;
      res_z_r <= '0;
    end
    if (state_r == S_LMAX && mul_done && !(d2_r > mul_prod)) begin
      res_x_r <= acc_x_r;
      res_z_r <= acc_z_r;
    end
    if (state_r == S_NXDIV && div_done) res_x_r <= scaled_out;
    if (state_r == S_NZDIV && div_done) res_z_r <= scaled_out;
    if (emit_fire) begin
      out_x_r <= res_x_r;
      out_z_r <= res_z_r;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = {out_z_r, out_x_r};

`ifndef ASSERT_OFF
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> (acc_x_r == '0) && (acc_z_r == '0))
    else $error("push accumulator not cleared after a result");
  a_falloff_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UXDIV) |-> (w_r <= 17'h10000))
    else $error("falloff weight above one");
  a_inside_radius: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WDIV) |-> ({1'b0, r_big} > dq_r))
    else $error("falloff computed for a neighbor outside the radius");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for separation_steering_accumulator: random and directed neighbor
// streams, checked against an in-bench fixed-point predictor of the separation push.
// Depends on ssa_pkg and the block itself.
module tb_top;
  import ssa_pkg::*;

  localparam int IDLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [95:0] in_tdata;
  logic in_tuser;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [47:0] out_tdata;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;

  separation_steering_accumulator dut (.*);

  // Predictor state and register copies.
  longint unsigned radius_q, max_push_q, min_dist_q, min_push_q;
  longint push_acc_x, push_acc_z;
  logic [47:0] push_queue[$];

  int fail_count;
  int send_idle_pct;
  int recv_stall_pct;
  bit recv_hold;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned abs_of(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint clamp_acc(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint unsigned scaled_comp(longint p, longint unsigned lq);
    longint unsigned m;
    m = (abs_of(p) * max_push_q * 256) / lq;
    if (m > max_push_q) m = max_push_q;
    return (p < 0) ? -m : m;
  endfunction

  // Adds one neighbor's weighted away vector to the predicted push.
  task automatic add_neighbor(longint dx, longint dz);
    longint unsigned adx, adz, d2, dq, big_r, w, tx, tz;
    adx = abs_of(dx);
    adz = abs_of(dz);
    if (adx >= 64'd8388608 || adz >= 64'd8388608) return;
    d2 = adx * adx + adz * adz;
    if (!(d2 > min_dist_q * min_dist_q && d2 < radius_q * radius_q)) return;
    dq = int_sqrt(d2 << 16);
    big_r = radius_q << 8;
    w = ((big_r - dq) << 16) / big_r;
    tx = (((adx << 24) / dq) * w) >> 16;
    tz = (((adz << 24) / dq) * w) >> 16;
    push_acc_x = clamp_acc(push_acc_x + ((dx < 0) ? -longint'(tx) : longint'(tx)));
    push_acc_z = clamp_acc(push_acc_z + ((dz < 0) ? -longint'(tz) : longint'(tz)));
  endtask

  task automatic predict_push(logic [95:0] data, bit present, bit last);
    longint ax, az, nx, nz;
    longint unsigned px, pz, len2, lq, ox, oz;
    ax = longint'($signed(data[23:0]));
    az = longint'($signed(data[47:24]));
    nx = longint'($signed(data[71:48]));
    nz = longint'($signed(data[95:72]));
    ox = 0;
    oz = 0;
    if (present) add_neighbor(ax - nx, az - nz);
    if (!last) return;
    if (radius_q != 0) begin
      px = abs_of(push_acc_x);
      pz = abs_of(push_acc_z);
      len2 = px * px + pz * pz;
      if (len2 >= min_push_q * min_push_q) begin
        if (len2 > max_push_q * max_push_q) begin
          lq = int_sqrt(len2 << 16);
          ox = scaled_comp(push_acc_x, lq);
          oz = scaled_comp(push_acc_z, lq);
        end else begin
          ox = push_acc_x;
          oz = push_acc_z;
        end
      end
    end
    push_queue.push_back({oz[23:0], ox[23:0]});
    push_acc_x = 0;
    push_acc_z = 0;
  endtask

  // Sends one item and updates the prediction once the transaction is taken.
  // The valid stays up afterwards; idle gaps and draining take it down.
  task automatic send_item(logic [23:0] ax, logic [23:0] az, logic [23:0] nx,
                           logic [23:0] nz, bit present, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {nz, nx, az, ax};
    in_tuser <= present;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_push({nz, nx, az, ax}, present, last);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (push_queue.size() != 0) @(posedge clk);
    // Items without a last flag may still be in flight.
    repeat (700) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_SEP_RADIUS: radius_q = val;
      REG_MAX_PUSH: max_push_q = val;
      REG_MIN_DISTANCE: min_dist_q = val[7:0];
      default: min_push_q = val[15:0];
    endcase
  endtask

  task automatic set_regs(logic [22:0] r, logic [22:0] mp, logic [7:0] md, logic [15:0] mn);
    wait_drained();
    write_reg(REG_SEP_RADIUS, r);
    write_reg(REG_MAX_PUSH, mp);
    write_reg(REG_MIN_DISTANCE, {15'd0, md});
    write_reg(REG_MIN_PUSH, {7'd0, mn});
    cfg_we <= 1'b0;
  endtask

  // Random neighbor near the agent, at a scale tied to the radius.
  task automatic send_near(logic [23:0] ax, logic [23:0] az, bit last);
    int span;
    span = (radius_q == 0) ? 600 : int'(radius_q) + 64;
    if (span > 4000000) span = 4000000;
    send_item(ax, az, 24'(ax - $urandom_range(2 * span) + span),
              24'(az - $urandom_range(2 * span) + span), 1'b1, last);
  endtask

  task automatic test_directed();
    send_item(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 1'b1, 1'b1);
    send_item(24'h800000, 24'h000000, 24'h7FFFFF, 24'h000000, 1'b1, 1'b1);
    send_item(24'd0, 24'd0, 24'd0, 24'd0, 1'b0, 1'b1);
    send_item(24'd0, 24'd0, 24'd0, 24'd0, 1'b1, 1'b1);
    send_item(24'd0, 24'd0, 24'd1, 24'd0, 1'b1, 1'b1);
    send_item(24'd0, 24'd0, 24'd2, 24'd0, 1'b1, 1'b0);
    send_item(24'd0, 24'd0, 24'd0, -24'd3, 1'b1, 1'b1);
    send_item(24'd100, 24'd100, 24'd100 + 24'd511, 24'd100, 1'b1, 1'b1);
    send_item(24'd100, 24'd100, 24'd100 + 24'd512, 24'd100, 1'b1, 1'b1);
    send_item(24'd0, 24'd0, 24'h0000F0, 24'hFFFF10, 1'b1, 1'b1);
    send_item(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 1'b0, 1'b0);
    send_item(24'd5, 24'd5, 24'd6, 24'd6, 1'b1, 1'b1);
    // Many close neighbors drive the push well over the clamp length.
    repeat (6) send_item(24'd0, 24'd0, 24'd3, 24'd2, 1'b1, 1'b0);
    send_item(24'd0, 24'd0, 24'd3, 24'd2, 1'b1, 1'b1);
  endtask

  task automatic test_config_extremes();
    set_regs(23'd0, 23'd65536, 8'd1, 16'd1);
    send_item(24'd0, 24'd0, 24'd10, 24'd10, 1'b1, 1'b1);
    set_regs(23'h7FFFFF, 23'd4194304, 8'd255, 16'd65535);
    send_item(24'h7FFFFF, 24'h7FFFFF, 24'h000000, 24'h000000, 1'b1, 1'b0);
    send_item(24'h000000, 24'h000000, 24'h000100, 24'h000000, 1'b1, 1'b0);
    send_item(24'h000000, 24'h000000, 24'h0000FF, 24'h000000, 1'b1, 1'b1);
    // Saturate the accumulator with a long list of close neighbors.
    set_regs(23'h7FFFFF, 23'd4194304, 8'd0, 16'd0);
    repeat (200) send_item(24'd0, 24'd0, 24'd1, -24'd1, 1'b1, 1'b0);
    send_item(24'd0, 24'd0, 24'd0, 24'd0, 1'b0, 1'b1);
    set_regs(23'd1, 23'd0, 8'd0, 16'd0);
    send_item(24'd0, 24'd0, 24'd0, 24'd0, 1'b1, 1'b1);
    send_item(24'd0, 24'd0, 24'd0, 24'd0, 1'b0, 1'b1);
  endtask

  task automatic test_random(int count);
    logic [23:0] ax, az;
    int k;
    k = 0;
    while (k < count) begin
      ax = 24'($urandom);
      az = 24'($urandom);
      if ($urandom_range(9) == 0) begin
        send_item(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                  1'($urandom), 1'($urandom));
        k++;
      end else begin
        repeat ($urandom_range(5)) begin
          if ($urandom_range(7) == 0) begin
            send_item(ax, az, 24'($urandom), 24'($urandom), 1'($urandom), 1'b0);
          end else begin
            send_near(ax, az, 1'b0);
          end
          k++;
        end
        send_near(ax, az, 1'b1);
        k++;
      end
    end
  endtask

  task automatic random_regs();
    case ($urandom_range(2))
      0: set_regs(23'($urandom_range(2000)), 23'($urandom_range(200000)), 8'($urandom),
                  16'($urandom_range(3000)));
      1: set_regs(23'($urandom), 23'($urandom_range(4194304)), 8'($urandom),
                  16'($urandom));
      default: set_regs(23'($urandom_range(600)), 23'($urandom_range(4194304)),
                        8'($urandom_range(4)), 16'd1);
    endcase
  endtask

  task automatic test_backpressure();
    recv_hold = 1'b1;
    repeat (8) send_near(24'd0, 24'd0, 1'b1);
    recv_hold = 1'b0;
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      if (push_queue.size() == 0) begin
        $error("unexpected push transaction %h", out_tdata);
        fail_count++;
      end else begin
        if (out_tdata[23:0] !== push_queue[0][23:0]) begin
          $error("push_x expected %h actual %h", push_queue[0][23:0], out_tdata[23:0]);
          fail_count++;
        end
        if (out_tdata[47:24] !== push_queue[0][47:24]) begin
          $error("push_z expected %h actual %h", push_queue[0][47:24], out_tdata[47:24]);
          fail_count++;
        end
        void'(push_queue.pop_front());
      end
    end
    out_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // The long hold-off is counted here, independent of the sender.
  always @(posedge clk) begin
    if (recv_hold) begin
      repeat (3000) @(posedge clk);
      recv_hold = 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    fail_count = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold = 1'b0;
    radius_q = 512;
    max_push_q = 65536;
    min_dist_q = 1;
    min_push_q = 1;
    push_acc_x = 0;
    push_acc_z = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_config_extremes();
    set_regs(23'd512, 23'd65536, 8'd1, 16'd1);
    test_backpressure();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 87; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 87; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      random_regs();
      test_random(100);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/ssa_pkg.sv
design/ssa_mul.sv
design/ssa_div.sv
design/ssa_sqrt.sv
design/separation_steering_accumulator.sv
bench/tb_top.sv
